/* hdl/sdo_rst_pkg.sv */
// Types and constants for the SDO response state tracker.
// No dependencies; imported by the interfaces, the core, the table checker and the testbench top.
package sdo_rst_pkg;

  typedef logic [2:0]  action_t;
  typedef logic [10:0] node_t;
  typedef logic [3:0]  dlc_t;
  typedef logic [4:0]  flags_t;

  localparam action_t ACT_RECEIVE  = 3'd0;
  localparam action_t ACT_REGISTER = 3'd1;
  localparam action_t ACT_QUERY    = 3'd2;
  localparam action_t ACT_ENABLE   = 3'd3;
  localparam action_t ACT_CLEAR    = 3'd4;

  localparam logic [7:0]  CMD_UPLOAD_4B = 8'h43;
  localparam logic [7:0]  CMD_UPLOAD_2B = 8'h4B;
  localparam logic [15:0] OBJ_POSITION  = 16'h6064;
  localparam logic [15:0] OBJ_CURRENT   = 16'h6077;
  localparam logic [15:0] OBJ_VELOCITY  = 16'h606C;
  localparam logic [15:0] OBJ_STATUS    = 16'h6041;
  localparam dlc_t        DLC_FULL      = 4'd8;

  localparam int STS_ENABLED_BIT = 2;
  localparam int STS_FAULT_BIT   = 3;

  localparam int FL_POS = 0;
  localparam int FL_CUR = 1;
  localparam int FL_VEL = 2;
  localparam int FL_EN  = 3;
  localparam int FL_FLT = 4;

  localparam logic [15:0] VEL_MAX = 16'h7FFF;
  localparam logic [15:0] VEL_MIN = 16'h8000;

  typedef struct packed {
    action_t     action;
    node_t       can_id;
    logic        is_extended;
    logic        is_remote;
    dlc_t        frame_length;
    logic [63:0] payload;
    logic        enable_value;
  } item_t;

  typedef struct packed {
    logic               frame_used;
    logic               table_full;
    logic               entry_found;
    logic signed [31:0] position;
    logic signed [15:0] current;
    logic signed [15:0] velocity;
    logic               position_valid;
    logic               current_valid;
    logic               velocity_valid;
    logic               enabled;
    logic               faulted;
  } result_t;

endpackage

/* hdl/sdo_rst_in_if.sv */
// Input channel of the SDO response state tracker: one action beat.
// Depends on sdo_rst_pkg.
interface sdo_rst_in_if import sdo_rst_pkg::*; ();
  logic        valid;
  logic        ready;
  action_t     action;
  node_t       can_id;
  logic        is_extended;
  logic        is_remote;
  dlc_t        frame_length;
  logic [63:0] payload;
  logic        enable_value;

  modport source (output valid, action, can_id, is_extended, is_remote, frame_length,
                  payload, enable_value, input ready);
  modport sink (input valid, action, can_id, is_extended, is_remote, frame_length,
                payload, enable_value, output ready);
endinterface

/* hdl/sdo_rst_out_if.sv */
// Result channel of the SDO response state tracker: one result beat.
// Depends on sdo_rst_pkg.
interface sdo_rst_out_if import sdo_rst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               frame_used;
  logic               table_full;
  logic               entry_found;
  logic signed [31:0] position;
  logic signed [15:0] current;
  logic signed [15:0] velocity;
  logic               position_valid;
  logic               current_valid;
  logic               velocity_valid;
  logic               enabled;
  logic               faulted;

  modport source (output valid, frame_used, table_full, entry_found, position, current,
                  velocity, position_valid, current_valid, velocity_valid, enabled,
                  faulted, input ready);
  modport sink (input valid, frame_used, table_full, entry_found, position, current,
                velocity, position_valid, current_valid, velocity_valid, enabled,
                faulted, output ready);
endinterface

/* hdl/sdo_response_state_tracker_core.sv */
// An accepted input beat passes through the input register, then the node-table
// lookup/update into the result register, before its result beat is offered.
// Throughput: one beat per cycle while the result channel is not stalled; the
// parallel match over MAX_NODES slots and the single result register set the pace.
// Reset (rst_n low, synchronous): all slots free and unregistered, both
// pipeline stages empty.
module sdo_response_state_tracker_core import sdo_rst_pkg::*; #(
  parameter int MAX_NODES = 8
) (
  input logic           clk,
  input logic           rst_n,
  sdo_rst_in_if.sink    in_ch,
  sdo_rst_out_if.source out_ch
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  item_t   item_r;
  logic    item_vld_r;
  result_t res_r;
  logic    res_vld_r;

  logic               slot_used_r  [MAX_NODES];
  logic               slot_reg_r   [MAX_NODES];
  node_t              slot_node_r  [MAX_NODES];
  logic signed [31:0] slot_pos_r   [MAX_NODES];
  logic        [15:0] slot_cur_r   [MAX_NODES];
  logic        [15:0] slot_vel_r   [MAX_NODES];
  flags_t             slot_flags_r [MAX_NODES];

  logic advance, fire, in_fire;

  assign advance      = !res_vld_r || out_ch.ready;
  assign fire         = item_vld_r && advance;
  assign in_ch.ready  = !item_vld_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // slot lookup
  logic [MAX_NODES-1:0] match, regm, free, regd;
  logic [IDX_W-1:0]     hit_idx, free_idx, sel;
  logic                 hit, have_free, slot_ok, accepted;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      match[i] = (slot_used_r[i] || slot_reg_r[i]) && (slot_node_r[i] == item_r.can_id);
      regm[i]  = slot_reg_r[i] && (slot_node_r[i] == item_r.can_id);
      free[i]  = !slot_used_r[i] && !slot_reg_r[i];
      regd[i]  = slot_reg_r[i];
    end
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
      if (free[i]) free_idx = IDX_W'(i);
    end
  end

  assign hit       = |match;
  assign have_free = |free;
  assign sel       = hit ? hit_idx : free_idx;
  assign slot_ok   = hit || have_free;
  assign accepted  = (|regm) || !(|regd);

  // current contents of the chosen slot; a fresh slot reads as zero
  logic               b_used, b_reg;
  logic signed [31:0] b_pos;
  logic        [15:0] b_cur, b_vel;
  flags_t             b_flags;

  assign b_used  = hit && slot_used_r[sel];
  assign b_reg   = hit && slot_reg_r[sel];
  assign b_pos   = hit ? slot_pos_r[sel] : '0;
  assign b_cur   = hit ? slot_cur_r[sel] : '0;
  assign b_vel   = hit ? slot_vel_r[sel] : '0;
  assign b_flags = hit ? slot_flags_r[sel] : '0;

  // frame decode
  logic [7:0]  cmd;
  logic [15:0] obj;
  logic [31:0] v32;
  logic [15:0] vel_sat;
  logic        frame_ok, is_4b;

  assign cmd   = item_r.payload[7:0];
  assign obj   = item_r.payload[23:8];
  assign v32   = item_r.payload[63:32];
  assign is_4b = (cmd == CMD_UPLOAD_4B);

  assign frame_ok = !item_r.is_extended && !item_r.is_remote &&
                    (item_r.frame_length >= DLC_FULL) && accepted &&
                    (is_4b || (cmd == CMD_UPLOAD_2B));

  always_comb begin
    if (!v32[31] && (v32[30:15] != '0))
      vel_sat = VEL_MAX;
    else if (v32[31] && (v32[30:15] != '1))
      vel_sat = VEL_MIN;
    else
      vel_sat = v32[15:0];
  end

  // next slot contents and result
  logic               n_used, n_reg, wr_slot, clr_reg;
  logic signed [31:0] n_pos;
  logic        [15:0] n_cur, n_vel;
  flags_t             n_flags;
  result_t            res_nxt;

  always_comb begin
    n_used  = b_used;
    n_reg   = b_reg;
    n_pos   = b_pos;
    n_cur   = b_cur;
    n_vel   = b_vel;
    n_flags = b_flags;
    wr_slot = 1'b0;
    clr_reg = 1'b0;
    res_nxt = '0;
    case (item_r.action)
      ACT_RECEIVE: begin
        if (frame_ok) begin
          if (!slot_ok) begin
            res_nxt.table_full = 1'b1;
          end else begin
            wr_slot = 1'b1;
            n_used  = 1'b1;
            if (obj == OBJ_POSITION && is_4b) begin
              n_pos              = v32;
              n_flags[FL_POS]    = 1'b1;
              res_nxt.frame_used = 1'b1;
            end else if (obj == OBJ_CURRENT) begin
              n_cur              = v32[15:0];
              n_flags[FL_CUR]    = 1'b1;
              res_nxt.frame_used = 1'b1;
            end else if (obj == OBJ_VELOCITY && is_4b) begin
              n_vel              = vel_sat;
              n_flags[FL_VEL]    = 1'b1;
              res_nxt.frame_used = 1'b1;
            end else if (obj == OBJ_STATUS) begin
              n_flags[FL_EN]     = v32[STS_ENABLED_BIT];
              n_flags[FL_FLT]    = v32[STS_FAULT_BIT];
              res_nxt.frame_used = 1'b1;
            end
          end
        end
      end
      ACT_REGISTER, ACT_QUERY: begin
        if (!slot_ok) begin
          res_nxt.table_full = 1'b1;
        end else begin
          wr_slot = 1'b1;
          n_reg   = 1'b1;
        end
        if (item_r.action == ACT_QUERY && b_used) begin
          res_nxt.entry_found    = 1'b1;
          res_nxt.position       = b_flags[FL_POS] ? b_pos : '0;
          res_nxt.current        = b_flags[FL_CUR] ? b_cur : '0;
          res_nxt.velocity       = b_flags[FL_VEL] ? b_vel : '0;
          res_nxt.position_valid = b_flags[FL_POS];
          res_nxt.current_valid  = b_flags[FL_CUR];
          res_nxt.velocity_valid = b_flags[FL_VEL];
          res_nxt.enabled        = b_flags[FL_EN];
          res_nxt.faulted        = b_flags[FL_FLT];
        end
      end
      ACT_ENABLE: begin
        if (!slot_ok) begin
          res_nxt.table_full = 1'b1;
        end else begin
          wr_slot        = 1'b1;
          n_reg          = 1'b1;
          n_used         = 1'b1;
          n_flags[FL_EN] = item_r.enable_value;
        end
      end
      ACT_CLEAR: begin
        clr_reg = 1'b1;
      end
      default: ;
    endcase
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_fire)
        item_vld_r <= 1'b1;
      else if (fire)
        item_vld_r <= 1'b0;
      if (fire)
        res_vld_r <= 1'b1;
      else if (out_ch.ready)
        res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.action       <= in_ch.action;
      item_r.can_id       <= in_ch.can_id;
      item_r.is_extended  <= in_ch.is_extended;
      item_r.is_remote    <= in_ch.is_remote;
      item_r.frame_length <= in_ch.frame_length;
      item_r.payload      <= in_ch.payload;
      item_r.enable_value <= in_ch.enable_value;
    end
    if (fire)
      res_r <= res_nxt;
  end

  // slot occupancy marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        slot_used_r[i] <= 1'b0;
        slot_reg_r[i]  <= 1'b0;
      end
    end else if (fire) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        if (clr_reg)
          slot_reg_r[i] <= 1'b0;
        else if (wr_slot && sel == IDX_W'(i)) begin
          slot_used_r[i] <= n_used;
          slot_reg_r[i]  <= n_reg;
        end
      end
    end
  end

  // slot data
  always_ff @(posedge clk) begin
    if (fire && wr_slot) begin
      slot_node_r[sel]  <= item_r.can_id;
      slot_pos_r[sel]   <= n_pos;
      slot_cur_r[sel]   <= n_cur;
      slot_vel_r[sel]   <= n_vel;
      slot_flags_r[sel] <= n_flags;
    end
  end

  assign out_ch.valid          = res_vld_r;
  assign out_ch.frame_used     = res_r.frame_used;
  assign out_ch.table_full     = res_r.table_full;
  assign out_ch.entry_found    = res_r.entry_found;
  assign out_ch.position       = res_r.position;
  assign out_ch.current        = res_r.current;
  assign out_ch.velocity       = res_r.velocity;
  assign out_ch.position_valid = res_r.position_valid;
  assign out_ch.current_valid  = res_r.current_valid;
  assign out_ch.velocity_valid = res_r.velocity_valid;
  assign out_ch.enabled        = res_r.enabled;
  assign out_ch.faulted        = res_r.faulted;

endmodule

/* hdl/sdo_rst_checker.sv */
// Port-level assertions for the SDO response state tracker core, and the
// bind that attaches them. Depends on sdo_response_state_tracker_core.
module sdo_rst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               frame_used,
  input logic               table_full,
  input logic               entry_found,
  input logic signed [31:0] position,
  input logic signed [15:0] current,
  input logic signed [15:0] velocity,
  input logic               position_valid,
  input logic               current_valid,
  input logic               velocity_valid,
  input logic               enabled,
  input logic               faulted
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_used_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(frame_used && table_full))
    else $error("frame_used and table_full both set");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !entry_found |-> !position_valid && !current_valid &&
      !velocity_valid && !enabled && !faulted && position == 0 &&
      current == 0 && velocity == 0)
    else $error("query fields set without an entry");

  a_invalid_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_found |-> (position_valid || position == 0) &&
      (current_valid || current == 0) && (velocity_valid || velocity == 0))
    else $error("value reported without its valid flag");

  a_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_found |-> !frame_used && !table_full)
    else $error("query result mixed with frame or full status");

endmodule

bind sdo_response_state_tracker_core sdo_rst_checker u_sdo_rst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .frame_used     (out_ch.frame_used),
  .table_full     (out_ch.table_full),
  .entry_found    (out_ch.entry_found),
  .position       (out_ch.position),
  .current        (out_ch.current),
  .velocity       (out_ch.velocity),
  .position_valid (out_ch.position_valid),
  .current_valid  (out_ch.current_valid),
  .velocity_valid (out_ch.velocity_valid),
  .enabled        (out_ch.enabled),
  .faulted        (out_ch.faulted)
);

/* tb/sdo_rst_table_check.sv */
`timescale 1ns / 100ps
// Checker for the SDO response state tracker: watches the action and result channels,
// keeps its own copy of the node table and compares every result beat field by field.
// Depends on sdo_rst_pkg and the two channel interfaces.
module sdo_rst_table_check import sdo_rst_pkg::*; #(
  parameter int MAX_NODES = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  sdo_rst_in_if  in_ch,
  sdo_rst_out_if out_ch,
  output int     errors,
  output int     waiting,
  output int     n_results,
  output int     n_stored,
  output int     n_hits,
  output int     n_full
);

  logic        tbl_used  [MAX_NODES];
  node_t       tbl_node  [MAX_NODES];
  logic        tbl_reg   [MAX_NODES];
  logic [31:0] tbl_pos   [MAX_NODES];
  logic [15:0] tbl_cur   [MAX_NODES];
  logic [15:0] tbl_vel   [MAX_NODES];
  flags_t      tbl_flags [MAX_NODES];

  result_t pending_results[$];
  result_t want;
  item_t   seen;

  int fail_cnt  = 0;
  int pend_cnt  = 0;
  int res_cnt   = 0;
  int store_cnt = 0;
  int hit_cnt   = 0;
  int full_cnt  = 0;

  assign errors    = fail_cnt;
  assign waiting   = pend_cnt;
  assign n_results = res_cnt;
  assign n_stored  = store_cnt;
  assign n_hits    = hit_cnt;
  assign n_full    = full_cnt;

  initial begin
    for (int i = 0; i < MAX_NODES; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_node[i]  = '0;
      tbl_reg[i]   = 1'b0;
      tbl_pos[i]   = '0;
      tbl_cur[i]   = '0;
      tbl_vel[i]   = '0;
      tbl_flags[i] = '0;
    end
  end

  function automatic int find_node(node_t n);
    for (int i = 0; i < MAX_NODES; i++)
      if ((tbl_used[i] || tbl_reg[i]) && tbl_node[i] == n) return i;
    return -1;
  endfunction

  function automatic int claim_slot(node_t n);
    int s;
    s = find_node(n);
    if (s >= 0) return s;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (!tbl_used[i] && !tbl_reg[i]) begin
        tbl_node[i]  = n;
        tbl_pos[i]   = '0;
        tbl_cur[i]   = '0;
        tbl_vel[i]   = '0;
        tbl_flags[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic node_accepted(node_t n);
    logic any_reg;
    any_reg = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (tbl_reg[i]) begin
        any_reg = 1'b1;
        if (tbl_node[i] == n) return 1'b1;
      end
    end
    return !any_reg;
  endfunction

  function automatic logic [15:0] clamp16(logic [31:0] v);
    if ($signed(v) < -32768) return VEL_MIN;
    if ($signed(v) > 32767) return VEL_MAX;
    return v[15:0];
  endfunction

  function automatic result_t track_action(item_t it);
    result_t     r;
    int          s;
    logic [7:0]  cmd;
    logic [15:0] obj;
    logic [31:0] v32;
    r   = '0;
    cmd = it.payload[7:0];
    obj = it.payload[23:8];
    v32 = it.payload[63:32];
    case (it.action)
      ACT_RECEIVE: begin
        if (!it.is_extended && !it.is_remote && it.frame_length >= DLC_FULL &&
            node_accepted(it.can_id) && (cmd == CMD_UPLOAD_4B || cmd == CMD_UPLOAD_2B)) begin
          s = claim_slot(it.can_id);
          if (s < 0) begin
            r.table_full = 1'b1;
          end else begin
            tbl_used[s] = 1'b1;
            if (obj == OBJ_POSITION && cmd == CMD_UPLOAD_4B) begin
              tbl_pos[s]           = v32;
              tbl_flags[s][FL_POS] = 1'b1;
              r.frame_used         = 1'b1;
            end else if (obj == OBJ_CURRENT) begin
              tbl_cur[s]           = v32[15:0];
              tbl_flags[s][FL_CUR] = 1'b1;
              r.frame_used         = 1'b1;
            end else if (obj == OBJ_VELOCITY && cmd == CMD_UPLOAD_4B) begin
              tbl_vel[s]           = clamp16(v32);
              tbl_flags[s][FL_VEL] = 1'b1;
              r.frame_used         = 1'b1;
            end else if (obj == OBJ_STATUS) begin
              tbl_flags[s][FL_EN]  = v32[STS_ENABLED_BIT];
              tbl_flags[s][FL_FLT] = v32[STS_FAULT_BIT];
              r.frame_used         = 1'b1;
            end
          end
        end
      end
      ACT_REGISTER, ACT_QUERY: begin
        s = claim_slot(it.can_id);
        if (s < 0) r.table_full = 1'b1;
        else tbl_reg[s] = 1'b1;
        if (it.action == ACT_QUERY && s >= 0 && tbl_used[s]) begin
          r.entry_found    = 1'b1;
          r.position       = tbl_flags[s][FL_POS] ? tbl_pos[s] : 32'd0;
          r.current        = tbl_flags[s][FL_CUR] ? tbl_cur[s] : 16'd0;
          r.velocity       = tbl_flags[s][FL_VEL] ? tbl_vel[s] : 16'd0;
          r.position_valid = tbl_flags[s][FL_POS];
          r.current_valid  = tbl_flags[s][FL_CUR];
          r.velocity_valid = tbl_flags[s][FL_VEL];
          r.enabled        = tbl_flags[s][FL_EN];
          r.faulted        = tbl_flags[s][FL_FLT];
        end
      end
      ACT_ENABLE: begin
        s = claim_slot(it.can_id);
        if (s < 0) begin
          r.table_full = 1'b1;
        end else begin
          tbl_reg[s]          = 1'b1;
          tbl_used[s]         = 1'b1;
          tbl_flags[s][FL_EN] = it.enable_value;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < MAX_NODES; i++) tbl_reg[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        res_cnt++;
        if (pending_results.size() == 0) begin
          $error("result beat with no outstanding action");
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (want.frame_used) store_cnt++;
          if (want.entry_found) hit_cnt++;
          if (want.table_full) full_cnt++;
          check_field("frame_used", want.frame_used, out_ch.frame_used);
          check_field("table_full", want.table_full, out_ch.table_full);
          check_field("entry_found", want.entry_found, out_ch.entry_found);
          check_field("position", want.position, out_ch.position);
          check_field("current", want.current, out_ch.current);
          check_field("velocity", want.velocity, out_ch.velocity);
          check_field("position_valid", want.position_valid, out_ch.position_valid);
          check_field("current_valid", want.current_valid, out_ch.current_valid);
          check_field("velocity_valid", want.velocity_valid, out_ch.velocity_valid);
          check_field("enabled", want.enabled, out_ch.enabled);
          check_field("faulted", want.faulted, out_ch.faulted);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.action       = in_ch.action;
        seen.can_id       = in_ch.can_id;
        seen.is_extended  = in_ch.is_extended;
        seen.is_remote    = in_ch.is_remote;
        seen.frame_length = in_ch.frame_length;
        seen.payload      = in_ch.payload;
        seen.enable_value = in_ch.enable_value;
        pending_results = {pending_results, track_action(seen)};
      end
      pend_cnt = pending_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the SDO response state tracker testbench: clock, reset, action stimulus and verdict.
// Depends on sdo_rst_pkg, the channel interfaces, the core and sdo_rst_table_check.
module tb_top;
  import sdo_rst_pkg::*;

  localparam int NODES = 8;
  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n;

  int src_idle  = 19;
  int sink_idle = 82;
  int cycles    = 0;
  int n_sent    = 0;
  int n_directed;

  int errors, waiting, n_results, n_stored, n_hits, n_full;

  node_t node_pool[10];

  sdo_rst_in_if  in_ch();
  sdo_rst_out_if out_ch();

  sdo_response_state_tracker_core #(.MAX_NODES(NODES)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sdo_rst_table_check #(.MAX_NODES(NODES)) u_table_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .waiting   (waiting),
    .n_results (n_results),
    .n_stored  (n_stored),
    .n_hits    (n_hits),
    .n_full    (n_full)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  function automatic item_t mk_frame(node_t n, logic [7:0] cmd, logic [15:0] obj,
                                     logic [31:0] v32);
    item_t it;
    it.action       = ACT_RECEIVE;
    it.can_id       = n;
    it.is_extended  = 1'b0;
    it.is_remote    = 1'b0;
    it.frame_length = DLC_FULL;
    it.payload      = {v32, 8'($urandom_range(255)), obj, cmd};
    it.enable_value = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic item_t mk_cmd(action_t a, node_t n, logic en);
    item_t it;
    it.action       = a;
    it.can_id       = n;
    it.is_extended  = 1'($urandom_range(1));
    it.is_remote    = 1'($urandom_range(1));
    it.frame_length = 4'($urandom_range(15));
    it.payload      = {$urandom, $urandom};
    it.enable_value = en;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int          r;
    node_t       n;
    logic [7:0]  cmd;
    logic [15:0] obj;
    logic [31:0] val;
    n   = ($urandom_range(9) == 0) ? node_t'($urandom_range(2047))
                                   : node_pool[$urandom_range(9)];
    cmd = ($urandom_range(3) == 0) ? CMD_UPLOAD_2B : CMD_UPLOAD_4B;
    case ($urandom_range(8))
      0, 1:    obj = OBJ_POSITION;
      2, 3:    obj = OBJ_CURRENT;
      4, 5:    obj = OBJ_VELOCITY;
      6, 7:    obj = OBJ_STATUS;
      default: obj = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(3))
      0: val = $urandom;
      1: val = 32'($urandom_range(131071)) - 32'd65536;
      2: begin
        case ($urandom_range(5))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'hFFFF_8000;
          3:       val = 32'h0000_7FFF;
          4:       val = 32'hFFFF_7FFF;
          default: val = 32'h0000_8000;
        endcase
      end
      default: val = 32'($urandom_range(15));
    endcase
    it = mk_frame(n, cmd, obj, val);
    r  = $urandom_range(99);
    if (r < 8) begin
      it.frame_length = 4'($urandom_range(15, 9));
    end else if (r < 55) begin
    end else if (r < 65) begin
      case ($urandom_range(3))
        0: it.is_extended = 1'b1;
        1: it.is_remote = 1'b1;
        2: it.frame_length = 4'($urandom_range(7));
        default: it.payload[7:0] = 8'($urandom_range(255));
      endcase
    end else if (r < 75) begin
      it = mk_cmd(ACT_REGISTER, n, 1'($urandom_range(1)));
    end else if (r < 85) begin
      it = mk_cmd(ACT_QUERY, n, 1'($urandom_range(1)));
    end else if (r < 93) begin
      it = mk_cmd(ACT_ENABLE, n, 1'($urandom_range(1)));
    end else if (r < 96) begin
      it = mk_cmd(ACT_CLEAR, n, 1'($urandom_range(1)));
    end else if (r < 98) begin
      it = mk_cmd(action_t'($urandom_range(7, 5)), n, 1'($urandom_range(1)));
    end else begin
      it = mk_cmd(action_t'($urandom_range(7)), node_t'($urandom_range(2047)),
                  1'($urandom_range(1)));
    end
    return it;
  endfunction

  task automatic drive_item(input item_t it);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.can_id       <= it.can_id;
    in_ch.is_extended  <= it.is_extended;
    in_ch.is_remote    <= it.is_remote;
    in_ch.frame_length <= it.frame_length;
    in_ch.payload      <= it.payload;
    in_ch.enable_value <= it.enable_value;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0 && cycles < LIMIT);
  endtask

  task automatic run_directed();
    item_t it;
    drive_item(mk_frame(11'h7FF, CMD_UPLOAD_4B, OBJ_POSITION, 32'h7FFF_FFFF));
    drive_item(mk_frame(11'h000, CMD_UPLOAD_2B, OBJ_CURRENT, 32'hFFFF_8000));
    drive_item(mk_frame(11'h000, CMD_UPLOAD_2B, OBJ_POSITION, 32'h0000_0001));
    drive_item(mk_frame(11'h7FF, CMD_UPLOAD_4B, OBJ_VELOCITY, 32'h8000_0000));
    drive_item(mk_frame(11'h7FF, CMD_UPLOAD_4B, OBJ_VELOCITY, 32'h0001_0000));
    drive_item(mk_frame(11'h7FF, CMD_UPLOAD_2B, OBJ_STATUS, 32'h0000_000C));
    drive_item(mk_frame(11'h7FF, CMD_UPLOAD_4B, 16'h1234, 32'hFFFF_FFFF));
    it = mk_frame(11'h7FF, CMD_UPLOAD_4B, OBJ_POSITION, 32'd5);
    it.is_extended = 1'b1;
    drive_item(it);
    it = mk_frame(11'h7FF, CMD_UPLOAD_4B, OBJ_POSITION, 32'd6);
    it.is_remote = 1'b1;
    drive_item(it);
    it = mk_frame(11'h7FF, CMD_UPLOAD_4B, OBJ_POSITION, 32'd7);
    it.frame_length = 4'd7;
    drive_item(it);
    it = mk_frame(11'h7FF, CMD_UPLOAD_2B, OBJ_CURRENT, 32'h0000_7FFF);
    it.frame_length = 4'd15;
    drive_item(it);
    drive_item(mk_frame(11'h7FF, 8'h60, OBJ_CURRENT, 32'd9));
    drive_item(mk_cmd(ACT_QUERY, 11'h7FF, 1'b0));
    drive_item(mk_cmd(ACT_REGISTER, 11'h7FF, 1'b0));
    drive_item(mk_frame(11'h000, CMD_UPLOAD_2B, OBJ_CURRENT, 32'd3));
    drive_item(mk_cmd(ACT_ENABLE, 11'h000, 1'b1));
    drive_item(mk_cmd(ACT_QUERY, 11'h000, 1'b0));
    for (int k = 1; k <= 6; k++) drive_item(mk_cmd(ACT_REGISTER, node_t'(k), 1'b0));
    drive_item(mk_cmd(ACT_REGISTER, 11'd9, 1'b0));
    drive_item(mk_cmd(ACT_QUERY, 11'd10, 1'b0));
    drive_item(mk_cmd(ACT_CLEAR, 11'd0, 1'b0));
    drive_item(mk_cmd(ACT_QUERY, 11'd1, 1'b0));
    drive_item(mk_cmd(action_t'(7), 11'd2, 1'b1));
    n_directed = n_sent;
  endtask

  task automatic run_random(input int count);
    item_t it;
    int    done;
    done = 0;
    while (done < count) begin
      it = random_item();
      drive_item(it);
      if (it.action <= ACT_CLEAR) done++;
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_RECEIVE;
    in_ch.can_id       <= '0;
    in_ch.is_extended  <= 1'b0;
    in_ch.is_remote    <= 1'b0;
    in_ch.frame_length <= '0;
    in_ch.payload      <= '0;
    in_ch.enable_value <= 1'b0;
    node_pool[0] = 11'h000;
    node_pool[1] = 11'h7FF;
    for (int k = 2; k < 10; k++) node_pool[k] = node_t'($urandom_range(2047));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(90);
    hold_until_drained();
    run_random(80);
    hold_until_drained();
    src_idle  = 82;
    sink_idle = 19;
    run_random(170);
    hold_until_drained();
    src_idle  = 0;
    sink_idle = 0;
    run_random(160);
    hold_until_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d action beats (%0d directed), checked %0d result beats.",
             n_sent, n_directed, n_results);
    $display("Frames stored: %0d, query hits: %0d, table-full drops: %0d.",
             n_stored, n_hits, n_full);
    if (errors == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
